FILE: rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // coordinate slots inside the packed input word, lowest first
  localparam int IDX_ASX = 0;
  localparam int IDX_ASY = 1;
  localparam int IDX_AEX = 2;
  localparam int IDX_AEY = 3;
  localparam int IDX_BSX = 4;
  localparam int IDX_BSY = 5;
  localparam int IDX_BEX = 6;
  localparam int IDX_BEY = 7;
  localparam int NUM_COORDS = 8;

  localparam int OUT_TDATA_W = 8;

  // per-item decision flags that travel down the pipeline
  typedef struct packed {
    logic det_zero;  // lines are parallel
    logic coin;      // line triples are proportional
    logic x_neg;     // x quotient is negative
    logic y_neg;     // y quotient is negative
    logic x_ovf;     // x quotient exceeds the tracked range
    logic y_ovf;     // y quotient exceeds the tracked range
  } sit_flags_t;

endpackage

FILE: rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Line equations, determinant and crossing numerators, five register stages.
// ----------------------------------------------------------------------------
module sit_front
  import sit_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NUM_COORDS*W-1:0] in_data,
  output logic                    out_valid,
  output logic [NUM_COORDS*W-1:0] out_pts,
  output logic signed [3*W+3:0]   out_xn,
  output logic signed [3*W+3:0]   out_yn,
  output logic signed [2*W+2:0]   out_det,
  output sit_flags_t              out_flags
);

  localparam int AW   = W + 1;
  localparam int PW   = 2 * W + 1;
  localparam int CW   = 2 * W + 2;
  localparam int DPW  = 2 * W + 2;
  localparam int DETW = 2 * W + 3;
  localparam int MW   = 3 * W + 3;
  localparam int NW   = 3 * W + 4;
  localparam int NST  = 5;

  logic [NST-1:0]          v_r;
  logic [NUM_COORDS*W-1:0] pts_r [NST];

  // stage 1: normals
  logic signed [AW-1:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [AW-1:0] a1_nxt, b1_nxt, a2_nxt, b2_nxt;
  logic signed [W-1:0]  i_asx, i_asy, i_aex, i_aey, i_bsx, i_bsy, i_bex, i_bey;

  assign i_asx = in_data[IDX_ASX*W +: W];
  assign i_asy = in_data[IDX_ASY*W +: W];
  assign i_aex = in_data[IDX_AEX*W +: W];
  assign i_aey = in_data[IDX_AEY*W +: W];
  assign i_bsx = in_data[IDX_BSX*W +: W];
  assign i_bsy = in_data[IDX_BSY*W +: W];
  assign i_bex = in_data[IDX_BEX*W +: W];
  assign i_bey = in_data[IDX_BEY*W +: W];

  assign a1_nxt = AW'(i_aey) - AW'(i_asy);
  assign b1_nxt = AW'(i_asx) - AW'(i_aex);
  assign a2_nxt = AW'(i_bey) - AW'(i_bsy);
  assign b2_nxt = AW'(i_bsx) - AW'(i_bex);

  // stage 2: products for offsets and determinant
  logic signed [W-1:0]   s1_asx, s1_asy, s1_bsx, s1_bsy;
  logic signed [PW-1:0]  pa1_r, pb1_r, pa2_r, pb2_r;
  logic signed [PW-1:0]  pa1_nxt, pb1_nxt, pa2_nxt, pb2_nxt;
  logic signed [DPW-1:0] d1_r, d2_r, d1_nxt, d2_nxt;
  logic signed [AW-1:0]  s2_a1_r, s2_b1_r, s2_a2_r, s2_b2_r;

  assign s1_asx = pts_r[0][IDX_ASX*W +: W];
  assign s1_asy = pts_r[0][IDX_ASY*W +: W];
  assign s1_bsx = pts_r[0][IDX_BSX*W +: W];
  assign s1_bsy = pts_r[0][IDX_BSY*W +: W];

  assign pa1_nxt = PW'(a1_r) * PW'(s1_asx);
  assign pb1_nxt = PW'(b1_r) * PW'(s1_asy);
  assign pa2_nxt = PW'(a2_r) * PW'(s1_bsx);
  assign pb2_nxt = PW'(b2_r) * PW'(s1_bsy);
  assign d1_nxt  = DPW'(a1_r) * DPW'(b2_r);
  assign d2_nxt  = DPW'(a2_r) * DPW'(b1_r);

  // stage 3: offsets and determinant
  logic signed [CW-1:0]   c1_r, c2_r, c1_nxt, c2_nxt;
  logic signed [DETW-1:0] det_r, det_nxt, det4_r;
  logic signed [AW-1:0]   s3_a1_r, s3_b1_r, s3_a2_r, s3_b2_r;

  assign c1_nxt  = -(CW'(pa1_r) + CW'(pb1_r));
  assign c2_nxt  = -(CW'(pa2_r) + CW'(pb2_r));
  assign det_nxt = DETW'(d1_r) - DETW'(d2_r);

  // stage 4: cross products of normals and offsets
  logic signed [MW-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [MW-1:0] m1_nxt, m2_nxt, m3_nxt, m4_nxt;

  assign m1_nxt = MW'(s3_b1_r) * MW'(c2_r);
  assign m2_nxt = MW'(s3_b2_r) * MW'(c1_r);
  assign m3_nxt = MW'(c1_r) * MW'(s3_a2_r);
  assign m4_nxt = MW'(c2_r) * MW'(s3_a1_r);

  // stage 5: numerators and parallel-case flags
  logic signed [NW-1:0]   xn_r, yn_r, xn_nxt, yn_nxt;
  logic signed [DETW-1:0] det5_r;
  logic                   coin_r, dz_r, coin_nxt, dz_nxt;

  assign xn_nxt   = NW'(m1_r) - NW'(m2_r);
  assign yn_nxt   = NW'(m3_r) - NW'(m4_r);
  assign coin_nxt = (m1_r == m2_r) && (m3_r == m4_r);
  assign dz_nxt   = (det4_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts_r[0] <= in_data;
      for (int k = 1; k < NST; k++) begin
        pts_r[k] <= pts_r[k-1];
      end
      a1_r    <= a1_nxt;
      b1_r    <= b1_nxt;
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      pa1_r   <= pa1_nxt;
      pb1_r   <= pb1_nxt;
      pa2_r   <= pa2_nxt;
      pb2_r   <= pb2_nxt;
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
      s2_a1_r <= a1_r;
      s2_b1_r <= b1_r;
      s2_a2_r <= a2_r;
      s2_b2_r <= b2_r;
      c1_r    <= c1_nxt;
      c2_r    <= c2_nxt;
      det_r   <= det_nxt;
      s3_a1_r <= s2_a1_r;
      s3_b1_r <= s2_b1_r;
      s3_a2_r <= s2_a2_r;
      s3_b2_r <= s2_b2_r;
      m1_r    <= m1_nxt;
      m2_r    <= m2_nxt;
      m3_r    <= m3_nxt;
      m4_r    <= m4_nxt;
      det4_r  <= det_r;
      xn_r    <= xn_nxt;
      yn_r    <= yn_nxt;
      coin_r  <= coin_nxt;
      dz_r    <= dz_nxt;
      det5_r  <= det4_r;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_pts   = pts_r[NST-1];
  assign out_xn    = xn_r;
  assign out_yn    = yn_r;
  assign out_det   = det5_r;

  always_comb begin
    out_flags          = '0;
    out_flags.det_zero = dz_r;
    out_flags.coin     = coin_r;
  end

endmodule

FILE: rtl/sit_div.sv
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring division of both numerators by the determinant,
// one quotient bit per stage, with an overflow flag for far crossings.
// ----------------------------------------------------------------------------
module sit_div
  import sit_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NUM_COORDS*W-1:0] in_pts,
  input  logic signed [3*W+3:0]   in_xn,
  input  logic signed [3*W+3:0]   in_yn,
  input  logic signed [2*W+2:0]   in_det,
  input  sit_flags_t              in_flags,
  output logic                    out_valid,
  output logic [NUM_COORDS*W-1:0] out_pts,
  output logic [W:0]              out_qx,
  output logic [W:0]              out_qy,
  output sit_flags_t              out_flags
);

  localparam int NW   = 3 * W + 4;
  localparam int DETW = 2 * W + 3;
  localparam int QB   = W + 1;
  localparam int LW   = NW + 1;

  logic [QB:0]             v_r;
  logic [LW-1:0]           rx_r  [QB+1];
  logic [LW-1:0]           ry_r  [QB+1];
  logic [QB-1:0]           qx_r  [QB+1];
  logic [QB-1:0]           qy_r  [QB+1];
  logic [DETW-1:0]         ud_r  [QB+1];
  logic [NUM_COORDS*W-1:0] pts_r [QB+1];
  sit_flags_t              fl_r  [QB+1];

  logic [LW-1:0]   rx_nxt [QB+1];
  logic [LW-1:0]   ry_nxt [QB+1];
  logic [QB-1:0]   qx_nxt [QB+1];
  logic [QB-1:0]   qy_nxt [QB+1];
  logic [NW-1:0]   ux, uy;
  logic [DETW-1:0] ud;
  logic [LW-1:0]   lim;
  sit_flags_t      fl_nxt;

  // prep: magnitudes, quotient signs, overflow against ud << QB
  assign ux  = in_xn[NW-1] ? NW'(-in_xn) : NW'(in_xn);
  assign uy  = in_yn[NW-1] ? NW'(-in_yn) : NW'(in_yn);
  assign ud  = in_det[DETW-1] ? DETW'(-in_det) : DETW'(in_det);
  assign lim = LW'(ud) << QB;

  always_comb begin
    fl_nxt       = in_flags;
    fl_nxt.x_neg = in_xn[NW-1] ^ in_det[DETW-1];
    fl_nxt.y_neg = in_yn[NW-1] ^ in_det[DETW-1];
    fl_nxt.x_ovf = (LW'(ux) >= lim);
    fl_nxt.y_ovf = (LW'(uy) >= lim);
  end

  always_comb begin
    logic [LW-1:0] sh;
    int            i;
    rx_nxt[0] = LW'(ux);
    ry_nxt[0] = LW'(uy);
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    for (int k = 0; k < QB; k++) begin
      i  = QB - 1 - k;
      sh = LW'(ud_r[k]) << i;
      if (rx_r[k] >= sh) begin
        rx_nxt[k+1] = rx_r[k] - sh;
        qx_nxt[k+1] = qx_r[k] | (QB'(1) << i);
      end else begin
        rx_nxt[k+1] = rx_r[k];
        qx_nxt[k+1] = qx_r[k];
      end
      if (ry_r[k] >= sh) begin
        ry_nxt[k+1] = ry_r[k] - sh;
        qy_nxt[k+1] = qy_r[k] | (QB'(1) << i);
      end else begin
        ry_nxt[k+1] = ry_r[k];
        qy_nxt[k+1] = qy_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ud_r[0]  <= ud;
      pts_r[0] <= in_pts;
      fl_r[0]  <= fl_nxt;
      for (int k = 0; k <= QB; k++) begin
        rx_r[k] <= rx_nxt[k];
        ry_r[k] <= ry_nxt[k];
        qx_r[k] <= qx_nxt[k];
        qy_r[k] <= qy_nxt[k];
      end
      for (int k = 1; k <= QB; k++) begin
        ud_r[k]  <= ud_r[k-1];
        pts_r[k] <= pts_r[k-1];
        fl_r[k]  <= fl_r[k-1];
      end
    end
  end

  assign out_valid = v_r[QB];
  assign out_pts   = pts_r[QB];
  assign out_qx    = qx_r[QB];
  assign out_qy    = qy_r[QB];
  assign out_flags = fl_r[QB];

endmodule

FILE: rtl/sit_check.sv
// ----------------------------------------------------------------------------
// sit_check
// Extent test of the crossing point and the output register.
// ----------------------------------------------------------------------------
module sit_check
  import sit_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NUM_COORDS*W-1:0] in_pts,
  input  logic [W:0]              in_qx,
  input  logic [W:0]              in_qy,
  input  sit_flags_t              in_flags,
  output logic                    out_valid,
  output logic                    out_hit
);

  localparam int QW = W + 2;

  function automatic logic in_span(input logic signed [QW-1:0] v,
                                   input logic signed [W-1:0]  e0,
                                   input logic signed [W-1:0]  e1);
    logic signed [QW-1:0] x0, x1;
    x0 = QW'(e0);
    x1 = QW'(e1);
    return (x0 < x1) ? ((v >= x0) && (v <= x1)) : ((v >= x1) && (v <= x0));
  endfunction

  logic signed [QW-1:0] xp, yp;
  logic                 in_ext, hit_nxt, valid_r, hit_r;

  assign xp = in_flags.x_neg ? -QW'(in_qx) : QW'(in_qx);
  assign yp = in_flags.y_neg ? -QW'(in_qy) : QW'(in_qy);

  assign in_ext = in_span(xp, in_pts[IDX_ASX*W +: W], in_pts[IDX_AEX*W +: W])
               && in_span(xp, in_pts[IDX_BSX*W +: W], in_pts[IDX_BEX*W +: W])
               && in_span(yp, in_pts[IDX_ASY*W +: W], in_pts[IDX_AEY*W +: W])
               && in_span(yp, in_pts[IDX_BSY*W +: W], in_pts[IDX_BEY*W +: W]);

  assign hit_nxt = in_flags.det_zero ? in_flags.coin
                 : (!in_flags.x_ovf && !in_flags.y_ovf && in_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_hit   = hit_r;

endmodule

FILE: rtl/segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Segment pair intersection test, one pair in and one hit per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_*    | in  | tdata: a_start_x, a_start_y, a_end_x, a_end_y,
//          |     |        b_start_x, b_start_y, b_end_x, b_end_y
//  out_*   | out | tdata: hit, zero padded to a byte
//
//  One transfer accepted per cycle unless held. The pipeline has five
//  arithmetic stages, one divider prep stage, COORD_WIDTH + 1 quotient-bit
//  stages of the restoring divider, and the output register.
//  The whole pipeline holds while out_tvalid is high and out_tready is low;
//  in_tready follows that hold, so nothing is dropped or repeated.
//  Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module segment_intersection_test_top
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [NUM_COORDS*COORD_WIDTH-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit, then zeros
  output logic [OUT_TDATA_W-1:0]            out_tdata
);

  localparam int W = COORD_WIDTH;

  logic                    en;
  logic                    f_valid, d_valid, hit;
  logic [NUM_COORDS*W-1:0] f_pts, d_pts;
  logic signed [3*W+3:0]   f_xn, f_yn;
  logic signed [2*W+2:0]   f_det;
  logic [W:0]              d_qx, d_qy;
  sit_flags_t              f_flags, d_flags;

  // advance unless a finished result is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  sit_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (f_valid),
    .out_pts   (f_pts),
    .out_xn    (f_xn),
    .out_yn    (f_yn),
    .out_det   (f_det),
    .out_flags (f_flags)
  );

  sit_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_pts    (f_pts),
    .in_xn     (f_xn),
    .in_yn     (f_yn),
    .in_det    (f_det),
    .in_flags  (f_flags),
    .out_valid (d_valid),
    .out_pts   (d_pts),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_flags (d_flags)
  );

  sit_check #(.W(W)) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_pts    (d_pts),
    .in_qx     (d_qx),
    .in_qy     (d_qy),
    .in_flags  (d_flags),
    .out_valid (out_tvalid),
    .out_hit   (hit)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, hit};

endmodule

FILE: rtl/sit_top_chk.sv
// ----------------------------------------------------------------------------
// sit_top_chk
// Port-level checks of the segment intersection test, bound to the top level.
// ----------------------------------------------------------------------------
module sit_top_chk
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [NUM_COORDS*COORD_WIDTH-1:0] in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [OUT_TDATA_W-1:0]            out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // input side stalls exactly when a held result blocks the pipeline
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output hold");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("nonzero padding in result");

endmodule

bind segment_intersection_test_top sit_top_chk #(.COORD_WIDTH(COORD_WIDTH)) u_sit_top_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
